/* rtl/core/apm_pkg.sv */
// Shared types and constants for the attitude PID motor mixer.
// Used by the register file, controller and datapath; depends on nothing.
`default_nettype none

package apm_pkg;

   // Field widths fixed by the stream format
   localparam int VALUE_W     = 17;   // roll/pitch value, signed
   localparam int GAIN_W      = 16;   // Q4.12 gains and Q0.16 tick
   localparam int RATE_W      = 16;   // stored rate, signed Q.4
   localparam int MUL_W       = 17;   // signed multiplier operand
   localparam int PROD_W      = 34;   // signed multiplier result
   localparam int CHUNK_W     = 16;   // integral slice per partial product
   localparam int CHUNK_IDX_W = 2;    // enough for integrals up to 64 bits
   localparam int MOTOR_W     = 8;    // motor drive field
   localparam int TICK_FRAC   = 16;   // angle*tick is Q.24, integral is Q.8
   localparam int CMD_FRAC    = 20;   // command sum is Q.20
   localparam int RATE_SHIFT  = 4;    // kd*rate is Q.16, align to Q.20
   localparam int CMD_BIAS    = 128;

   localparam int CSR_IDX_W   = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROLL_KP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROLL_KI  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROLL_KD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_KP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_KI = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_KD = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TICK     = 3'd6;

   // Multiplier operand selects
   localparam logic [1:0] MUL_TICK = 2'd0;   // tick * angle
   localparam logic [1:0] MUL_KP   = 2'd1;   // kp * angle
   localparam logic [1:0] MUL_KI   = 2'd2;   // ki * integral slice
   localparam logic [1:0] MUL_KD   = 2'd3;   // kd * rate

   // Accumulator operations, applied to the previous cycle's product
   localparam logic [2:0] ACC_NONE   = 3'd0;
   localparam logic [2:0] ACC_INTEG  = 3'd1;  // update integral, load bias
   localparam logic [2:0] ACC_ADD_KP = 3'd2;
   localparam logic [2:0] ACC_ADD_KI = 3'd3;
   localparam logic [2:0] ACC_SUB_KD = 3'd4;
   localparam logic [2:0] ACC_STORE  = 3'd5;  // clamp and latch motor pair

   typedef struct packed {
      logic [GAIN_W-1:0] roll_kp;
      logic [GAIN_W-1:0] roll_ki;
      logic [GAIN_W-1:0] roll_kd;
      logic [GAIN_W-1:0] pitch_kp;
      logic [GAIN_W-1:0] pitch_ki;
      logic [GAIN_W-1:0] pitch_kd;
      logic [GAIN_W-1:0] tick_interval;
   } gains_type;

   typedef struct packed {
      logic [1:0]             mul_sel;
      logic [CHUNK_IDX_W-1:0] chunk;
      logic [2:0]             acc_op;
      logic                   axis;       // 0 roll, 1 pitch
      logic                   load_rate;
      logic                   load_angle;
      logic                   publish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

/* rtl/core/attitude_pid_motor_mixer.sv */
// Top level of the two-axis attitude PID with four-motor mix.
// Instantiates apm_csr, apm_ctrl and apm_dp; depends on apm_pkg.
//
//   channel | dir | payload
//   req_    | in  | tuser: func; tdata: roll_value[16:0], pitch_value[33:17]
//   rsp_    | out | tdata: motor_front, motor_right, motor_back, motor_left
//   csr_    | in  | index 0..6 = roll kp/ki/kd, pitch kp/ki/kd, tick
//
// A gyro item only loads the rates and leaves the input ready. An inclinometer item
// runs both axes through the single shared 17x17 multiplier, doing (NCH+3) products
// per axis, NCH = ceil(INTEGRAL_BITS/16); the input is not ready meanwhile.
// A stalled result stays in the output register; the next item is taken
// meanwhile, and a second result waits until the first transfers.
// Synchronous reset restores the gains and clears the integrals and rates.
`default_nettype none

module attitude_pid_motor_mixer #(
   parameter int INTEGRAL_BITS = 32,
   parameter int MOTOR_MAX     = 255
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [39:0]  req_tdata,   // roll_value[16:0], pitch_value[33:17], zero pad
   input  wire logic [0:0]   req_tuser,   // func
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic [31:0]  rsp_tdata,   // front[7:0], right[15:8], back[23:16], left[31:24]
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);
   import apm_pkg::*;

   gains_type  gains;
   cmd_type    cmd;
   status_type status;

   apm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .gains     (gains)
   );

   apm_ctrl #(
      .INTEGRAL_BITS (INTEGRAL_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser[0]),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   apm_dp #(
      .INTEGRAL_BITS (INTEGRAL_BITS),
      .MOTOR_MAX     (MOTOR_MAX)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .gains       (gains),
      .roll_value  (req_tdata[VALUE_W-1:0]),
      .pitch_value (req_tdata[2*VALUE_W-1:VALUE_W]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

`default_nettype wire

/* rtl/core/apm_csr.sv */
// Gain and tick register file for the attitude PID motor mixer.
// Depends on apm_pkg for the register indexes and the gains struct.
`default_nettype none

module apm_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [apm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [apm_pkg::GAIN_W-1:0]       csr_wdata,
   output apm_pkg::gains_type                    gains
);
   import apm_pkg::*;

   gains_type gains_ff, gains_in;

   always_comb begin
      gains_in = gains_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ROLL_KP:  gains_in.roll_kp       = csr_wdata;
            REG_ROLL_KI:  gains_in.roll_ki       = csr_wdata;
            REG_ROLL_KD:  gains_in.roll_kd       = csr_wdata;
            REG_PITCH_KP: gains_in.pitch_kp      = csr_wdata;
            REG_PITCH_KI: gains_in.pitch_ki      = csr_wdata;
            REG_PITCH_KD: gains_in.pitch_kd      = csr_wdata;
            REG_TICK:     gains_in.tick_interval = csr_wdata;
            default: ;    // drop writes beyond the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.roll_kp       <= 16'd8192;
         gains_ff.roll_ki       <= 16'd41;
         gains_ff.roll_kd       <= 16'd819;
         gains_ff.pitch_kp      <= 16'd4096;
         gains_ff.pitch_ki      <= 16'd410;
         gains_ff.pitch_kd      <= 16'd819;
         gains_ff.tick_interval <= 16'd1049;
      end else begin
         gains_ff <= gains_in;
      end
   end

   assign gains = gains_ff;

endmodule

`default_nettype wire

/* rtl/core/apm_ctrl.sv */
// Sequencer for the attitude PID motor mixer: accepts items and steps the
// shared multiplier and accumulator through both axes. Depends on apm_pkg.
`default_nettype none

module apm_ctrl #(
   parameter int INTEGRAL_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_func,
   output      logic                 req_tready,
   input  wire apm_pkg::status_type  status,
   output apm_pkg::cmd_type          cmd
);
   import apm_pkg::*;

   localparam int NCH       = (INTEGRAL_BITS + CHUNK_W - 1) / CHUNK_W;
   localparam int LAST_STEP = NCH + 4;
   localparam int STEP_W    = $clog2(LAST_STEP + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              axis_ff, axis_in;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      axis_in    = axis_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.mul_sel = MUL_TICK;
      cmd.acc_op  = ACC_NONE;
      cmd.axis    = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            // hold off transfers while reset is asserted
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               if (req_func) begin
                  cmd.load_angle = 1'b1;
                  state_in       = ST_RUN;
                  step_in        = '0;
                  axis_in        = 1'b0;
               end else begin
                  cmd.load_rate = 1'b1;
               end
            end
         end
         ST_RUN: begin
            // product of step n is accumulated in step n+1
            if (step_ff == STEP_W'(0)) begin
               cmd.mul_sel = MUL_TICK;
            end else if (step_ff == STEP_W'(1)) begin
               cmd.acc_op  = ACC_INTEG;
               cmd.mul_sel = MUL_KP;
            end else if (step_ff <= STEP_W'(NCH + 1)) begin
               cmd.acc_op  = (step_ff == STEP_W'(2)) ? ACC_ADD_KP : ACC_ADD_KI;
               cmd.mul_sel = MUL_KI;
               cmd.chunk   = CHUNK_IDX_W'(step_ff - STEP_W'(2));
            end else if (step_ff == STEP_W'(NCH + 2)) begin
               cmd.acc_op  = ACC_ADD_KI;
               cmd.mul_sel = MUL_KD;
            end else if (step_ff == STEP_W'(NCH + 3)) begin
               cmd.acc_op  = ACC_SUB_KD;
            end else begin
               cmd.acc_op  = ACC_STORE;
            end

            if (step_ff == STEP_W'(LAST_STEP)) begin
               step_in = '0;
               if (axis_ff) begin
                  state_in = ST_WAIT;
               end else begin
                  axis_in = 1'b1;
               end
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_WAIT: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         axis_ff  <= axis_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/apm_dp.sv */
// Datapath of the attitude PID motor mixer: sample and state registers,
// shared 17x17 multiplier, command accumulator, clamp and output register.
// Depends on apm_pkg; driven by apm_ctrl commands.
`default_nettype none

module apm_dp #(
   parameter int INTEGRAL_BITS = 32,
   parameter int MOTOR_MAX     = 255
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire apm_pkg::cmd_type                    cmd,
   output apm_pkg::status_type                      status,
   input  wire apm_pkg::gains_type                  gains,
   input  wire logic signed [apm_pkg::VALUE_W-1:0]  roll_value,
   input  wire logic signed [apm_pkg::VALUE_W-1:0]  pitch_value,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [4*apm_pkg::MOTOR_W-1:0]       rsp_tdata
);
   import apm_pkg::*;

   localparam int IB     = INTEGRAL_BITS;
   localparam int NCH    = (IB + CHUNK_W - 1) / CHUNK_W;
   localparam int CHK_W  = $clog2(NCH);
   localparam int ACC_W  = IB + 18;
   localparam int SUM_W  = ACC_W - CMD_FRAC;
   localparam int MW     = $clog2(MOTOR_MAX + 1);
   localparam int INC_W  = PROD_W - TICK_FRAC;

   logic signed [VALUE_W-1:0] angle_ff [2];
   logic signed [VALUE_W-1:0] angle_in [2];
   logic signed [RATE_W-1:0]  rate_ff  [2];
   logic signed [RATE_W-1:0]  rate_in  [2];
   logic signed [IB-1:0]      integ_ff [2];
   logic signed [IB-1:0]      integ_in [2];
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [CHK_W-1:0]          chunk_ff, chunk_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [MOTOR_W-1:0]        motor_ff [4];
   logic [MOTOR_W-1:0]        motor_in [4];
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [4*MOTOR_W-1:0]      rsp_data_ff, rsp_data_in;

   logic signed [GAIN_W-1:0]  kp_sel, ki_sel, kd_sel;
   logic signed [VALUE_W-1:0] angle_sel;
   logic signed [RATE_W-1:0]  rate_sel;
   logic signed [IB-1:0]      integ_sel;
   logic signed [MUL_W-1:0]   chunk_arr [NCH];
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [INC_W-1:0]   step_inc;
   logic signed [IB:0]        integ_sum;
   logic signed [IB-1:0]      integ_sat;
   logic signed [ACC_W-1:0]   prod_ext, ki_term;
   logic [SUM_W-1:0]          acc_hi;
   logic [MW-1:0]             cmd_val, comp_val;

   function automatic logic signed [RATE_W-1:0] sat_rate(
      input logic signed [VALUE_W-1:0] v
   );
      logic signed [RATE_W-1:0] r;
      if (v[VALUE_W-1] != v[VALUE_W-2]) begin
         r = v[VALUE_W-1] ? {1'b1, {(RATE_W-1){1'b0}}} : {1'b0, {(RATE_W-1){1'b1}}};
      end else begin
         r = v[RATE_W-1:0];
      end
      return r;
   endfunction

   // Operand selection for the current axis
   always_comb begin
      kp_sel    = cmd.axis ? gains.pitch_kp : gains.roll_kp;
      ki_sel    = cmd.axis ? gains.pitch_ki : gains.roll_ki;
      kd_sel    = cmd.axis ? gains.pitch_kd : gains.roll_kd;
      angle_sel = angle_ff[cmd.axis];
      rate_sel  = rate_ff[cmd.axis];
      integ_sel = integ_ff[cmd.axis];
   end

   // Integral split into unsigned low slices and a signed top slice
   always_comb begin
      for (int k = 0; k < NCH - 1; k++) begin
         chunk_arr[k] = {1'b0, integ_sel[k*CHUNK_W +: CHUNK_W]};
      end
      chunk_arr[NCH-1] = MUL_W'($signed(integ_sel[IB-1:CHUNK_W*(NCH-1)]));
   end

   always_comb begin
      case (cmd.mul_sel)
         MUL_TICK: begin
            mul_a = {1'b0, gains.tick_interval};
            mul_b = angle_sel;
         end
         MUL_KP: begin
            mul_a = MUL_W'(kp_sel);
            mul_b = angle_sel;
         end
         MUL_KI: begin
            mul_a = MUL_W'(ki_sel);
            mul_b = chunk_arr[cmd.chunk[CHK_W-1:0]];
         end
         MUL_KD: begin
            mul_a = MUL_W'(kd_sel);
            mul_b = MUL_W'(rate_sel);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in  = mul_a * mul_b;
      chunk_in = cmd.chunk[CHK_W-1:0];
   end

   // Integral update: floor angle*tick to Q.8, saturate the sum
   always_comb begin
      step_inc  = prod_ff[PROD_W-1:TICK_FRAC];
      integ_sum = (IB+1)'(integ_sel) + (IB+1)'(step_inc);
      if (integ_sum[IB] != integ_sum[IB-1]) begin
         integ_sat = integ_sum[IB] ? {1'b1, {(IB-1){1'b0}}} : {1'b0, {(IB-1){1'b1}}};
      end else begin
         integ_sat = integ_sum[IB-1:0];
      end
   end

   // Command clamp
   always_comb begin
      acc_hi = acc_ff[ACC_W-1:CMD_FRAC];
      if (acc_ff[ACC_W-1]) begin
         cmd_val = '0;
      end else if (acc_hi > SUM_W'(MOTOR_MAX)) begin
         cmd_val = MW'(MOTOR_MAX);
      end else begin
         cmd_val = acc_hi[MW-1:0];
      end
      comp_val = MW'(MOTOR_MAX) - cmd_val;
   end

   always_comb begin
      prod_ext = ACC_W'(prod_ff);
      ki_term  = prod_ext << (CHUNK_W * chunk_ff);

      angle_in = angle_ff;
      rate_in  = rate_ff;
      integ_in = integ_ff;
      acc_in   = acc_ff;
      motor_in = motor_ff;

      if (cmd.load_angle) begin
         angle_in[0] = roll_value;
         angle_in[1] = pitch_value;
      end
      if (cmd.load_rate) begin
         rate_in[0] = sat_rate(roll_value);
         rate_in[1] = sat_rate(pitch_value);
      end

      case (cmd.acc_op)
         ACC_INTEG: begin
            integ_in[cmd.axis] = integ_sat;
            acc_in = ACC_W'(CMD_BIAS) <<< CMD_FRAC;
         end
         ACC_ADD_KP: acc_in = acc_ff + prod_ext;
         ACC_ADD_KI: acc_in = acc_ff + ki_term;
         ACC_SUB_KD: acc_in = acc_ff - (prod_ext <<< RATE_SHIFT);
         ACC_STORE: begin
            if (cmd.axis) begin
               motor_in[1] = cmd_val[MOTOR_W-1:0];
               motor_in[3] = comp_val[MOTOR_W-1:0];
            end else begin
               motor_in[0] = cmd_val[MOTOR_W-1:0];
               motor_in[2] = comp_val[MOTOR_W-1:0];
            end
         end
         default: ;
      endcase
   end

   // Output register; a new result may load as the old one transfers
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {motor_ff[3], motor_ff[2], motor_ff[1], motor_ff[0]};
      end
      status.out_free = !rsp_valid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff[0]   <= '0;
         rate_ff[1]   <= '0;
         integ_ff[0]  <= '0;
         integ_ff[1]  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rate_ff      <= rate_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff    <= angle_in;
      prod_ff     <= prod_in;
      chunk_ff    <= chunk_in;
      acc_ff      <= acc_in;
      motor_ff    <= motor_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/core/apm_checker.sv */
// Port-level checks for attitude_pid_motor_mixer, bound to the top level.
// Depends only on the top level's ports and its MOTOR_MAX parameter.
`default_nettype none

module apm_checker #(
   parameter int MOTOR_MAX = 255
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [0:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   localparam logic [7:0] MIX_SUM = 8'(MOTOR_MAX);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // opposite motors mirror each other
   a_roll_mix: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 8'(rsp_tdata[7:0] + rsp_tdata[23:16]) == MIX_SUM)
      else $error("front and back motors do not mirror");

   a_pitch_mix: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 8'(rsp_tdata[15:8] + rsp_tdata[31:24]) == MIX_SUM)
      else $error("right and left motors do not mirror");

   // an angle transfer starts a computation, a rate transfer does not
   a_angle_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] |=> !req_tready)
      else $error("input ready during computation");

   a_rate_free: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser[0] |=> req_tready)
      else $error("rate transfer stalled the input");

endmodule

bind attitude_pid_motor_mixer apm_checker #(
   .MOTOR_MAX (MOTOR_MAX)
) u_apm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
